[src/gaussian_blur_3x3_rgb_macros.svh]
// Assertion macros for the 3x3 Gaussian blur block.
// Used by the port checker; expects clk and rst_n in scope.
`ifndef GAUSSIAN_BLUR_3X3_RGB_MACROS_SVH
`define GAUSSIAN_BLUR_3X3_RGB_MACROS_SVH

// same-cycle implication
`define GB3_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GB3_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/gb3_pkg.sv]
// Shared constants, types and helpers for the 3x3 Gaussian blur block.
// No dependencies.
`timescale 1ns / 1ps

package gb3_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 4096;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int WID_W  = $clog2(MAX_WIDTH + 1);
    localparam int HGT_W  = $clog2(MAX_HEIGHT + 1);
    localparam int IROW_W = $clog2(MAX_HEIGHT + 3);
    localparam int OROW_W = $clog2(MAX_HEIGHT);

    localparam int CH_W   = 8;
    localparam int N_CH   = 3;
    localparam int PIX_W  = CH_W * N_CH;
    localparam int SUM_W  = CH_W + 4;
    localparam int N_TAPS = 9;

    localparam int REG_WIDTH_W  = 12;
    localparam int REG_HEIGHT_W = 13;
    localparam int CFG_W        = 13;
    localparam int N_REGS       = 2;
    localparam int CFG_IDX_W    = $clog2(N_REGS);

    localparam logic [REG_WIDTH_W-1:0]  WIDTH_RESET  = REG_WIDTH_W'(640);
    localparam logic [REG_HEIGHT_W-1:0] HEIGHT_RESET = REG_HEIGHT_W'(480);

    // log2 of the kernel weight at each tap, row-major
    localparam int KERNEL_SHIFT [N_TAPS] = '{0, 1, 0, 1, 2, 1, 0, 1, 0};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = CFG_IDX_W'(0),
        REG_FRAME_HEIGHT = CFG_IDX_W'(1)
    } cfg_reg_t;

    typedef enum logic {
        FUNC_PIXEL = 1'b0,
        FUNC_FLUSH = 1'b1
    } func_t;

    typedef struct packed {
        logic [WID_W-1:0] width;
        logic [HGT_W-1:0] height;
        logic             restart;
    } frame_cfg_t;

    typedef struct packed {
        logic             valid;
        logic             emit;
        logic [COL_W-1:0] col;
        logic [PIX_W-1:0] pix;
    } issue_t;

    typedef struct packed {
        logic [PIX_W-1:0] upper;
        logic [PIX_W-1:0] lower;
    } ls_entry_t;

endpackage

[src/gb3_line_store.sv]
// Line store: both buffered rows in one word per column, one write and
// one registered read port. Depends on gb3_pkg.
`timescale 1ns / 1ps

module gb3_line_store
(
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [gb3_pkg::COL_W-1:0] rd_addr,
    output gb3_pkg::ls_entry_t       rd_data,
    input  logic                     wr_en,
    input  logic [gb3_pkg::COL_W-1:0] wr_addr,
    input  gb3_pkg::ls_entry_t       wr_data
);
    import gb3_pkg::*;

    ls_entry_t mem [MAX_WIDTH];
    ls_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[src/gb3_ctrl.sv]
// Input side: scan counters, word filtering and line-store read issue.
// Depends on gb3_pkg.
`timescale 1ns / 1ps

module gb3_ctrl
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  gb3_pkg::frame_cfg_t       cfg,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      func,
    input  logic [gb3_pkg::CH_W-1:0]  red_in,
    input  logic [gb3_pkg::CH_W-1:0]  green_in,
    input  logic [gb3_pkg::CH_W-1:0]  blue_in,
    input  logic                      s1_free,
    output gb3_pkg::issue_t           issue
);
    import gb3_pkg::*;

    logic [COL_W-1:0]  col_reg, col_next;
    logic [IROW_W-1:0] row_reg, row_next;

    logic              accept;
    logic              flush;
    logic              draining;
    logic              take;
    logic              last_col;
    logic              frame_done;
    logic [COL_W-1:0]  col;

    assign in_ready = s1_free;
    assign accept   = in_valid && s1_free;
    assign flush    = (func_t'(func) == FUNC_FLUSH);
    assign draining = (row_reg >= IROW_W'(cfg.height));
    assign take     = accept && (flush == draining);

    assign col        = ((WID_W'(col_reg)) >= cfg.width) ? '0 : col_reg;
    assign last_col   = ((WID_W'(col) + WID_W'(1)) >= cfg.width);
    assign frame_done = draining && (row_reg == (IROW_W'(cfg.height) + IROW_W'(1)));

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (cfg.restart)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (take)
        begin
            if (frame_done)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (last_col)
            begin
                col_next = '0;
                row_next = row_reg + IROW_W'(1);
            end
            else
            begin
                col_next = col + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    always_comb
    begin
        issue.valid = take;
        issue.emit  = !((row_reg == '0) || ((row_reg == IROW_W'(1)) && (col == '0)));
        issue.col   = col;
        issue.pix   = flush ? '0 : {red_in, green_in, blue_in};
    end

endmodule

[src/gb3_window.sv]
// Window stage: line-store write-back with bypass, 3x3 window, kernel
// sum and output register. Depends on gb3_pkg.
`timescale 1ns / 1ps

module gb3_window
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  gb3_pkg::frame_cfg_t       cfg,
    input  gb3_pkg::issue_t           issue,
    output logic                      s1_free,
    input  gb3_pkg::ls_entry_t        ls_rdata,
    output logic                      ls_wen,
    output logic [gb3_pkg::COL_W-1:0] ls_waddr,
    output gb3_pkg::ls_entry_t        ls_wdata,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [gb3_pkg::CH_W-1:0]  red_out,
    output logic [gb3_pkg::CH_W-1:0]  green_out,
    output logic [gb3_pkg::CH_W-1:0]  blue_out,
    output logic                      frame_end
);
    import gb3_pkg::*;

    issue_t            s1_reg, s1_next;
    logic              lw_valid_reg;
    logic [COL_W-1:0]  lw_addr_reg;
    ls_entry_t         lw_data_reg;
    logic [PIX_W-1:0]  win_reg [N_TAPS];
    logic [PIX_W-1:0]  win_next [N_TAPS];
    logic [PIX_W-1:0]  win_shift [N_TAPS];
    logic [COL_W-1:0]  ocol_reg, ocol_next;
    logic [OROW_W-1:0] orow_reg, orow_next;
    logic              out_valid_reg, out_valid_next;
    logic [CH_W-1:0]   red_reg, green_reg, blue_reg;
    logic              frame_end_reg;

    logic              out_free;
    logic              s1_go;
    logic              load;
    ls_entry_t         cur;
    logic              mask_top, mask_bot, mask_left, mask_right;
    logic              frame_last;
    logic [N_TAPS-1:0] tap_mask;
    logic [SUM_W-1:0]  ch_sum [N_CH];

    assign out_free = !out_valid_reg || out_ready;
    assign s1_go    = s1_reg.valid && (!s1_reg.emit || out_free);
    assign s1_free  = !s1_reg.valid || s1_go;
    assign load     = s1_go && s1_reg.emit;

    // read data predates the latest write to the same column
    assign cur = (lw_valid_reg && (lw_addr_reg == s1_reg.col)) ? lw_data_reg : ls_rdata;

    assign ls_wen         = s1_go;
    assign ls_waddr       = s1_reg.col;
    assign ls_wdata.upper = cur.lower;
    assign ls_wdata.lower = s1_reg.pix;

    always_comb
    begin
        s1_next = s1_reg;
        if (s1_free)
        begin
            s1_next = issue;
        end
    end

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            win_shift[r*3]     = win_reg[r*3 + 1];
            win_shift[r*3 + 1] = win_reg[r*3 + 2];
        end
        win_shift[2] = cur.upper;
        win_shift[5] = cur.lower;
        win_shift[8] = s1_reg.pix;
    end

    assign mask_top   = (orow_reg == '0);
    assign mask_bot   = ((HGT_W'(orow_reg) + HGT_W'(1)) >= cfg.height);
    assign mask_left  = (ocol_reg == '0);
    assign mask_right = ((WID_W'(ocol_reg) + WID_W'(1)) >= cfg.width);
    assign frame_last = mask_bot && mask_right;

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                tap_mask[r*3 + c] = ((r == 0) && mask_top) || ((r == 2) && mask_bot) ||
                                    ((c == 0) && mask_left) || ((c == 2) && mask_right);
            end
        end
        for (int ch = 0; ch < N_CH; ch++)
        begin
            ch_sum[ch] = '0;
            for (int t = 0; t < N_TAPS; t++)
            begin
                if (!tap_mask[t])
                begin
                    ch_sum[ch] = ch_sum[ch] +
                        (SUM_W'(win_shift[t][(N_CH - 1 - ch)*CH_W +: CH_W]) << KERNEL_SHIFT[t]);
                end
            end
        end
    end

    always_comb
    begin
        for (int t = 0; t < N_TAPS; t++)
        begin
            win_next[t] = win_reg[t];
            if (cfg.restart || (load && frame_last))
            begin
                win_next[t] = '0;
            end
            else if (s1_go)
            begin
                win_next[t] = win_shift[t];
            end
        end
    end

    always_comb
    begin
        ocol_next = ocol_reg;
        orow_next = orow_reg;
        if (cfg.restart || (load && frame_last))
        begin
            ocol_next = '0;
            orow_next = '0;
        end
        else if (load)
        begin
            if (mask_right)
            begin
                ocol_next = '0;
                orow_next = orow_reg + OROW_W'(1);
            end
            else
            begin
                ocol_next = ocol_reg + COL_W'(1);
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg        <= '0;
            lw_valid_reg  <= 1'b0;
            ocol_reg      <= '0;
            orow_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int t = 0; t < N_TAPS; t++)
            begin
                win_reg[t] <= '0;
            end
        end
        else
        begin
            s1_reg        <= s1_next;
            ocol_reg      <= ocol_next;
            orow_reg      <= orow_next;
            out_valid_reg <= out_valid_next;
            if (ls_wen)
            begin
                lw_valid_reg <= 1'b1;
            end
            for (int t = 0; t < N_TAPS; t++)
            begin
                win_reg[t] <= win_next[t];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ls_wen)
        begin
            lw_addr_reg <= ls_waddr;
            lw_data_reg <= ls_wdata;
        end
        if (load)
        begin
            red_reg       <= ch_sum[0][SUM_W-1 -: CH_W];
            green_reg     <= ch_sum[1][SUM_W-1 -: CH_W];
            blue_reg      <= ch_sum[2][SUM_W-1 -: CH_W];
            frame_end_reg <= frame_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign red_out   = red_reg;
    assign green_out = green_reg;
    assign blue_out  = blue_reg;
    assign frame_end = frame_end_reg;

endmodule

[src/gaussian_blur_3x3_rgb.sv]
// 3x3 Gaussian blur of an RGB stream. The word that completes a neighbourhood (one row plus
// one pixel later in the stream) passes s1_reg, then its result goes to the output register.
// Throughput: one word per cycle when not stalled; the line-store read-modify-write sets it.
// Reset: counters, window, out_valid cleared; width 640, height 480; line store undefined.
// Top level; depends on gb3_pkg, gb3_ctrl, gb3_line_store and gb3_window.
`timescale 1ns / 1ps

module gaussian_blur_3x3_rgb
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wen,
    input  logic [gb3_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [gb3_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          func,
    input  logic [gb3_pkg::CH_W-1:0]      red_in,
    input  logic [gb3_pkg::CH_W-1:0]      green_in,
    input  logic [gb3_pkg::CH_W-1:0]      blue_in,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [gb3_pkg::CH_W-1:0]      red_out,
    output logic [gb3_pkg::CH_W-1:0]      green_out,
    output logic [gb3_pkg::CH_W-1:0]      blue_out,
    output logic                          frame_end
);
    import gb3_pkg::*;

    logic [REG_WIDTH_W-1:0]  width_reg;
    logic [REG_HEIGHT_W-1:0] height_reg;
    frame_cfg_t              cfg;
    issue_t                  issue;
    logic                    s1_free;
    ls_entry_t               ls_rdata;
    logic                    ls_wen;
    logic [COL_W-1:0]        ls_waddr;
    ls_entry_t               ls_wdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_wen)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_FRAME_WIDTH:  width_reg  <= cfg_data[REG_WIDTH_W-1:0];
                REG_FRAME_HEIGHT: height_reg <= cfg_data[REG_HEIGHT_W-1:0];
                default:          ;
            endcase
        end
    end

    // clamp to the supported frame size
    always_comb
    begin
        if (width_reg == '0)
        begin
            cfg.width = WID_W'(1);
        end
        else if (32'(width_reg) > 32'(MAX_WIDTH))
        begin
            cfg.width = WID_W'(MAX_WIDTH);
        end
        else
        begin
            cfg.width = WID_W'(width_reg);
        end
        if (height_reg == '0)
        begin
            cfg.height = HGT_W'(1);
        end
        else if (32'(height_reg) > 32'(MAX_HEIGHT))
        begin
            cfg.height = HGT_W'(MAX_HEIGHT);
        end
        else
        begin
            cfg.height = HGT_W'(height_reg);
        end
        cfg.restart = cfg_wen;
    end

    gb3_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .func     (func),
        .red_in   (red_in),
        .green_in (green_in),
        .blue_in  (blue_in),
        .s1_free  (s1_free),
        .issue    (issue)
    );

    gb3_line_store u_line_store
    (
        .clk     (clk),
        .rd_en   (issue.valid),
        .rd_addr (issue.col),
        .rd_data (ls_rdata),
        .wr_en   (ls_wen),
        .wr_addr (ls_waddr),
        .wr_data (ls_wdata)
    );

    gb3_window u_window
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .issue     (issue),
        .s1_free   (s1_free),
        .ls_rdata  (ls_rdata),
        .ls_wen    (ls_wen),
        .ls_waddr  (ls_waddr),
        .ls_wdata  (ls_wdata),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .red_out   (red_out),
        .green_out (green_out),
        .blue_out  (blue_out),
        .frame_end (frame_end)
    );

endmodule

[src/gb3_checker.sv]
// Port-level checker for the blur top level, attached by bind.
// Depends on gb3_pkg and gaussian_blur_3x3_rgb_macros.svh.
`timescale 1ns / 1ps
`include "gaussian_blur_3x3_rgb_macros.svh"

module gb3_checker
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_ready,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic [gb3_pkg::CH_W-1:0] red_out,
    input logic [gb3_pkg::CH_W-1:0] green_out,
    input logic [gb3_pkg::CH_W-1:0] blue_out,
    input logic                     frame_end
);
    import gb3_pkg::*;

    logic [PIX_W:0] out_word;
    logic           out_stall;
    logic           in_take;

    assign out_word  = {red_out, green_out, blue_out, frame_end};
    assign out_stall = out_valid && !out_ready;
    assign in_take   = in_valid && in_ready;

    `GB3_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_word), "stalled word changed")

    `GB3_ASSERT_NOW(a_stall_cause, !in_ready, out_stall, "input stall without output stall")

    `GB3_ASSERT_NOW(a_out_source, $rose(out_valid), $past(in_take, 2), "word out with no word in")

endmodule

bind gaussian_blur_3x3_rgb gb3_checker u_gb3_checker (.*);

[dv/testbench.sv]
// Bench for gaussian_blur_3x3_rgb: directed, size-limit and random frames, stalls both sides.
// Every result word is checked against a blur predictor kept in this file.
// Depends on gb3_pkg and the gaussian_blur_3x3_rgb RTL.
`timescale 1ns / 1ps

module testbench;
    import gb3_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int SETTLE       = 6;
    localparam int STALL_LIMIT  = 5000;
    localparam int RANDOM_WORDS = 880;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic            last;
    } blur_px_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_wen;
    cfg_reg_t           cfg_index;
    logic [CFG_W-1:0]   cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic               func;
    logic [CH_W-1:0]    red_in;
    logic [CH_W-1:0]    green_in;
    logic [CH_W-1:0]    blue_in;
    logic               out_valid;
    logic               out_ready;
    logic [CH_W-1:0]    red_out;
    logic [CH_W-1:0]    green_out;
    logic [CH_W-1:0]    blue_out;
    logic               frame_end;

    // predictor state
    logic [PIX_W-1:0]        upper_row [MAX_WIDTH];
    logic [PIX_W-1:0]        lower_row [MAX_WIDTH];
    logic [PIX_W-1:0]        win [N_TAPS];
    logic [REG_WIDTH_W-1:0]  width_reg;
    logic [REG_HEIGHT_W-1:0] height_reg;
    int unsigned             in_col;
    int unsigned             in_row;
    int unsigned             out_col;
    int unsigned             out_row;
    blur_px_t                blurred_q [$];

    int errors = 0;
    int idle_run = 0;
    int burst_left = 0;
    bit steady_sender = 1'b0;
    bit hold_req = 1'b0;
    int hold_len = 0;

    gaussian_blur_3x3_rgb u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func),
        .red_in    (red_in),
        .green_in  (green_in),
        .blue_in   (blue_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .red_out   (red_out),
        .green_out (green_out),
        .blue_out  (blue_out),
        .frame_end (frame_end)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    function automatic int unsigned cols();
        int unsigned w;
        w = width_reg;
        if (w == 0) w = 1;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        return w;
    endfunction

    function automatic int unsigned rows();
        int unsigned h;
        h = height_reg;
        if (h == 0) h = 1;
        if (h > MAX_HEIGHT) h = MAX_HEIGHT;
        return h;
    endfunction

    function automatic void restart_frame();
        for (int i = 0; i < N_TAPS; i++)
            win[i] = '0;
        in_col  = 0;
        in_row  = 0;
        out_col = 0;
        out_row = 0;
    endfunction

    function automatic void apply_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] v);
        if (idx == REG_FRAME_WIDTH)
            width_reg = v[REG_WIDTH_W-1:0];
        else
            height_reg = v[REG_HEIGHT_W-1:0];
        restart_frame();
    endfunction

    function automatic void blur_predict(input logic f, input logic [CH_W-1:0] r, g, b);
        int unsigned     w, h, col, row, sum, sh, wt;
        int              ch, rr, cc;
        logic [PIX_W-1:0] pix, above, mid;
        logic [CH_W-1:0] chan [N_CH];
        bit              masked;
        blur_px_t        px;
        w = cols();
        h = rows();
        if ((f == FUNC_FLUSH) != (in_row >= h))
            return;
        pix = (f == FUNC_FLUSH) ? '0 : {r, g, b};
        col = in_col;
        row = in_row;
        if (col >= w)
            col = 0;
        above = upper_row[col];
        mid   = lower_row[col];
        upper_row[col] = mid;
        lower_row[col] = pix;
        for (rr = 0; rr < 3; rr++)
        begin
            win[rr * 3]     = win[rr * 3 + 1];
            win[rr * 3 + 1] = win[rr * 3 + 2];
        end
        win[2] = above;
        win[5] = mid;
        win[8] = pix;
        if (col + 1 >= w)
        begin
            in_col = 0;
            in_row = row + 1;
        end
        else
            in_col = col + 1;
        if (row == 0 || (row == 1 && col == 0))
            return;
        for (ch = 0; ch < N_CH; ch++)
        begin
            sh  = 16 - 8 * ch;
            sum = 0;
            for (rr = 0; rr < 3; rr++)
                for (cc = 0; cc < 3; cc++)
                begin
                    masked = (rr == 0 && out_row == 0) || (rr == 2 && out_row + 1 >= h) ||
                             (cc == 0 && out_col == 0) || (cc == 2 && out_col + 1 >= w);
                    if (!masked)
                    begin
                        wt  = (rr == 1 ? 2 : 1) * (cc == 1 ? 2 : 1);
                        sum += ((win[rr * 3 + cc] >> sh) & 24'hFF) * wt;
                    end
                end
            chan[ch] = CH_W'(sum / 16);
        end
        px.red   = chan[0];
        px.green = chan[1];
        px.blue  = chan[2];
        px.last  = (out_row + 1 >= h) && (out_col + 1 >= w);
        if (px.last)
            restart_frame();
        else if (out_col + 1 >= w)
        begin
            out_col = 0;
            out_row++;
        end
        else
            out_col++;
        blurred_q.push_back(px);
    endfunction

    function automatic logic [CH_W-1:0] rand_chan();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return CH_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic check_field(input string name, input logic [CH_W-1:0] want, got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // one word, sent in bursts with random gaps between them
    task automatic send_word(input logic f, input logic [CH_W-1:0] r, g, b);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            if (steady_sender)
                gap = 0;
            else if ($urandom_range(0, 9) == 0)
                gap = $urandom_range(8, 30);
            else
                gap = $urandom_range(0, 4);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        func     <= f;
        red_in   <= r;
        green_in <= g;
        blue_in  <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        blur_predict(f, r, g, b);
        @(negedge clk);
    endtask

    // drop valid and wait for every expected word plus the pipeline tail
    task automatic settle();
        in_valid <= 1'b0;
        burst_left = 0;
        while (blurred_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] v);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        apply_reg(idx, v);
        @(negedge clk);
        cfg_wen <= 1'b0;
        @(negedge clk);
    endtask

    task automatic reframe(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        settle();
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
    endtask

    task automatic send_pixels(input int unsigned n, input bit noisy);
        for (int unsigned i = 0; i < n; i++)
        begin
            if (noisy && $urandom_range(0, 29) == 0)
                send_word(FUNC_FLUSH, rand_chan(), rand_chan(), rand_chan());
            send_word(FUNC_PIXEL, rand_chan(), rand_chan(), rand_chan());
        end
    endtask

    task automatic drain_frame(input bit noisy);
        int unsigned n;
        n = cols() + 1;
        for (int unsigned i = 0; i < n; i++)
        begin
            if (noisy && $urandom_range(0, 19) == 0)
                send_word(FUNC_PIXEL, rand_chan(), rand_chan(), rand_chan());
            send_word(FUNC_FLUSH, rand_chan(), rand_chan(), rand_chan());
        end
    endtask

    task automatic test_default_height();
        settle();
        write_reg(REG_FRAME_WIDTH, CFG_W'(1));
        send_pixels(cols() * rows(), 1'b0);
        drain_frame(1'b0);
    endtask

    task automatic test_directed_frames();
        reframe(3, 3);
        send_word(FUNC_FLUSH, '1, '1, '1);
        for (int i = 0; i < 9; i++)
            send_word(FUNC_PIXEL, i[0] ? '1 : '0, CH_W'(i * 31), CH_W'(255 - i * 17));
        send_word(FUNC_PIXEL, '1, '1, '1);
        drain_frame(1'b0);
        // single row, top bit of the data ignored for the width
        reframe(13'h1004, 1);
        for (int i = 0; i < 4; i++)
            send_word(FUNC_PIXEL, '1, '1, '1);
        drain_frame(1'b0);
        // zero sizes act as one
        reframe(0, 0);
        send_word(FUNC_PIXEL, '1, 8'h80, 8'h7F);
        drain_frame(1'b0);
    endtask

    task automatic test_backpressure();
        reframe(16, 6);
        steady_sender = 1'b1;
        hold_len = 300;
        hold_req = 1'b1;
        send_pixels(cols() * rows(), 1'b0);
        drain_frame(1'b0);
        steady_sender = 1'b0;
        settle();
    endtask

    task automatic test_frame_limits();
        steady_sender = 1'b1;
        // width field wraps to zero and acts as one
        reframe(13'h1000, 3);
        send_pixels(cols() * rows(), 1'b0);
        drain_frame(1'b0);
        reframe(1, 12);
        send_pixels(cols() * rows(), 1'b0);
        drain_frame(1'b0);
        reframe(12, 1);
        send_pixels(cols() * rows(), 1'b0);
        drain_frame(1'b0);
        steady_sender = 1'b0;
    endtask

    task automatic test_random_frames();
        int unsigned done, n, cut, fw, fh;
        bit          need_cfg;
        done = 0;
        need_cfg = 1'b1;
        while (done < RANDOM_WORDS)
        begin
            if (need_cfg || $urandom_range(0, 1) == 0)
            begin
                fw = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 64) : $urandom_range(1, 10);
                fh = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
                reframe(CFG_W'(fw), CFG_W'(fh));
            end
            steady_sender = ($urandom_range(0, 3) == 0);
            n = cols() * rows();
            if ($urandom_range(0, 11) == 0)
            begin
                // abandon the frame part way
                cut = $urandom_range(0, n - 1);
                send_pixels(cut, 1'b1);
                done += cut;
                settle();
                need_cfg = 1'b1;
            end
            else
            begin
                send_pixels(n, 1'b1);
                drain_frame(1'b1);
                done += n + cols() + 1;
                need_cfg = 1'b0;
            end
        end
        steady_sender = 1'b0;
        settle();
    endtask

    // receiver: random stall rate that shifts over time, or a long hold-off on request
    initial
    begin
        int stall_pct;
        stall_pct = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (hold_len) @(negedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                if ($urandom_range(0, 63) == 0)
                    case ($urandom_range(0, 3))
                        0: stall_pct = 0;
                        1: stall_pct = 20;
                        2: stall_pct = 50;
                        default: stall_pct = 85;
                    endcase
                out_ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        blur_px_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (blurred_q.size() == 0)
            begin
                $display("%0t: unexpected word, expected none, got r=%0d g=%0d b=%0d end=%0d",
                         $time, red_out, green_out, blue_out, frame_end);
                errors++;
            end
            else
            begin
                want = blurred_q.pop_front();
                check_field("red_out", want.red, red_out);
                check_field("green_out", want.green, green_out);
                check_field("blue_out", want.blue, blue_out);
                check_field("frame_end", CH_W'(want.last), CH_W'(frame_end));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_run <= 0;
        else
            idle_run <= idle_run + 1;
        if (idle_run >= STALL_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles", $time, idle_run);
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        cfg_wen   = 1'b0;
        cfg_index = REG_FRAME_WIDTH;
        cfg_data  = '0;
        in_valid  = 1'b0;
        func      = FUNC_PIXEL;
        red_in    = '0;
        green_in  = '0;
        blue_in   = '0;
        width_reg  = WIDTH_RESET;
        height_reg = HEIGHT_RESET;
        for (int i = 0; i < MAX_WIDTH; i++)
        begin
            upper_row[i] = '0;
            lower_row[i] = '0;
        end
        restart_frame();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_default_height();
        test_directed_frames();
        test_backpressure();
        test_frame_limits();
        test_random_frames();
        repeat (SETTLE) @(posedge clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

[gaussian_blur_3x3_rgb.f]
+incdir+src
src/gb3_pkg.sv
src/gb3_line_store.sv
src/gb3_ctrl.sv
src/gb3_window.sv
src/gaussian_blur_3x3_rgb.sv
src/gb3_checker.sv
dv/testbench.sv
